@@ sv/clni_pkg.sv @@
`default_nettype none

package clni_pkg;

  // Request codes carried in the opcode field.
  typedef enum logic [1:0] {
    OP_INIT   = 2'd0,
    OP_CMD    = 2'd1,
    OP_DATA   = 2'd2,
    OP_CURSOR = 2'd3
  } op_e;

  // Sequencer states of the strobe engine.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  localparam int unsigned OpW       = 2;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned NibW      = 4;
  localparam int unsigned WaitW     = 16;
  localparam int unsigned InitSteps = 10;
  localparam int unsigned StepW     = $clog2(InitSteps);
  localparam int unsigned QueueDepth = 2;

  localparam logic [WaitW-1:0] GapReset   = 16'd50;
  localparam logic [ByteW-1:0] CmdSetDdram = 8'h80;
  localparam logic [StepW-1:0] InitLast   = StepW'(InitSteps - 1);
  localparam logic [StepW-1:0] ByteLast   = StepW'(1);

  // One classified request, as passed from the front end to the strobe engine.
  typedef struct packed {
    logic             is_init;
    logic             rs;
    logic [ByteW-1:0] byte_val;
    logic [WaitW-1:0] first_wait;
  } job_t;

  // Nibble and leading wait of one strobe.
  typedef struct packed {
    logic [NibW-1:0]  nibble;
    logic [WaitW-1:0] wait_us;
  } strobe_t;

  // Power-up sequence: four half-commands, then function set, clear and display on.
  function automatic strobe_t init_entry(logic [StepW-1:0] step);
    strobe_t s;
    s = '{nibble: 4'h0, wait_us: 16'd0};
    case (step)
      4'd0:    s = '{nibble: 4'h3, wait_us: 16'd15000};
      4'd1:    s = '{nibble: 4'h3, wait_us: 16'd5000};
      4'd2:    s = '{nibble: 4'h3, wait_us: 16'd100};
      4'd3:    s = '{nibble: 4'h2, wait_us: 16'd50};
      4'd4:    s = '{nibble: 4'h2, wait_us: 16'd50};
      4'd5:    s = '{nibble: 4'h0, wait_us: 16'd0};
      4'd6:    s = '{nibble: 4'h0, wait_us: 16'd50};
      4'd7:    s = '{nibble: 4'h1, wait_us: 16'd0};
      4'd8:    s = '{nibble: 4'h0, wait_us: 16'd2050};
      4'd9:    s = '{nibble: 4'hC, wait_us: 16'd0};
      default: s = '{nibble: 4'h0, wait_us: 16'd0};
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

@@ sv/clni_if.sv @@
`default_nettype none

// Request channel: one LCD request per item.
interface clni_req_if;
  logic                         valid;
  logic                         ready;
  logic [clni_pkg::OpW-1:0]     opcode;
  logic [clni_pkg::ByteW-1:0]   byte_value;
  modport source (output valid, opcode, byte_value, input ready);
  modport sink   (input valid, opcode, byte_value, output ready);
endinterface

// Strobe channel: one enable strobe per item.
interface clni_strobe_if;
  logic                         valid;
  logic                         ready;
  logic                         reg_select;
  logic [clni_pkg::NibW-1:0]    data_nibble;
  logic [clni_pkg::WaitW-1:0]   wait_us;
  logic                         last_strobe;
  modport source (output valid, reg_select, data_nibble, wait_us, last_strobe, input ready);
  modport sink   (input valid, reg_select, data_nibble, wait_us, last_strobe, output ready);
endinterface

// Configuration write channel for the character gap register.
interface clni_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [clni_pkg::WaitW-1:0]   data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

@@ sv/clni_front.sv @@
`default_nettype none

module clni_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  clni_req_if.sink         req_i,
  clni_cfg_if.sink         cfg_i,
  input  wire logic        queue_ready_i,
  output logic             push_o,
  output clni_pkg::job_t   job_o
);

  logic [clni_pkg::WaitW-1:0] gap_q, gap_d;
  clni_pkg::op_e              op;

  // The gap register takes every write; writes must arrive only while idle, which is not enforced.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    gap_d = gap_q;
    if (cfg_i.valid) begin
      gap_d = cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= clni_pkg::GapReset;
    end else begin
      gap_q <= gap_d;
    end
  end

  // A request is taken whenever the queue has room.
  assign req_i.ready = queue_ready_i;
  assign push_o      = req_i.valid && queue_ready_i;

  // Classify the request into what the strobe engine has to send.
  assign op = clni_pkg::op_e'(req_i.opcode);

  always_comb begin
    job_o = '{is_init: 1'b0, rs: 1'b0, byte_val: req_i.byte_value,
              first_wait: '0};
    unique case (op)
      clni_pkg::OP_INIT: begin
        job_o.is_init = 1'b1;
      end
      clni_pkg::OP_CMD: begin
        job_o.byte_val = req_i.byte_value;
      end
      clni_pkg::OP_DATA: begin
        job_o.rs         = 1'b1;
        job_o.first_wait = gap_q;
      end
      clni_pkg::OP_CURSOR: begin
        job_o.byte_val = clni_pkg::CmdSetDdram | req_i.byte_value;
      end
      default: begin
        job_o.is_init = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/clni_queue.sv @@
`default_nettype none

module clni_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire clni_pkg::job_t  push_data_i,
  output logic                 ready_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output clni_pkg::job_t       data_o
);

  localparam int unsigned PtrW   = $clog2(clni_pkg::QueueDepth);
  localparam int unsigned CountW = $clog2(clni_pkg::QueueDepth + 1);
  localparam logic [PtrW-1:0]   PtrLast = PtrW'(clni_pkg::QueueDepth - 1);
  localparam logic [CountW-1:0] CountFull = CountW'(clni_pkg::QueueDepth);

  clni_pkg::job_t      slot_q [clni_pkg::QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CountW-1:0]   count_q, count_d;

  assign ready_o = (count_q != CountFull);
  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CountW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage slots need no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  // The front end never pushes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> count_q != CountFull)
    else $error("queue overflow");

  // The engine never pops an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("queue underflow");

endmodule

`default_nettype wire

@@ sv/clni_back.sv @@
`default_nettype none

module clni_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            job_valid_i,
  input  wire clni_pkg::job_t  job_i,
  output logic                 pop_o,
  clni_strobe_if.source        strobe_o
);

  clni_pkg::state_e              state_q, state_d;
  clni_pkg::job_t                job_q;
  logic [clni_pkg::StepW-1:0]    step_q, step_d;
  logic                          out_valid_q, out_valid_d;
  logic                          out_rs_q, out_last_q;
  logic [clni_pkg::NibW-1:0]     out_nib_q;
  logic [clni_pkg::WaitW-1:0]    out_wait_q;
  clni_pkg::strobe_t             init_s, cur_s;
  logic                          cur_last;
  logic                          load;

  // Strobe for the current step: table lookup for init, nibble split otherwise.
  assign init_s = clni_pkg::init_entry(step_q);

  always_comb begin
    if (job_q.is_init) begin
      cur_s    = init_s;
      cur_last = (step_q == clni_pkg::InitLast);
    end else begin
      cur_s.nibble  = step_q[0] ? job_q.byte_val[3:0] : job_q.byte_val[7:4];
      cur_s.wait_us = step_q[0] ? '0 : job_q.first_wait;
      cur_last      = (step_q == clni_pkg::ByteLast);
    end
  end

  assign pop_o = (state_q == clni_pkg::ST_IDLE) && job_valid_i;
  assign load  = (state_q == clni_pkg::ST_RUN) && (!out_valid_q || strobe_o.ready);

  // Sequencer: take a job when idle, then issue one strobe per free output slot.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      clni_pkg::ST_IDLE: begin
        if (job_valid_i) begin
          state_d = clni_pkg::ST_RUN;
          step_d  = '0;
        end
      end
      clni_pkg::ST_RUN: begin
        if (load) begin
          step_d = step_q + clni_pkg::StepW'(1);
          if (cur_last) begin
            state_d = clni_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = clni_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (strobe_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= clni_pkg::ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Job and output payload registers.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (load) begin
      out_rs_q   <= job_q.rs;
      out_nib_q  <= cur_s.nibble;
      out_wait_q <= cur_s.wait_us;
      out_last_q <= cur_last;
    end
  end

  assign strobe_o.valid       = out_valid_q;
  assign strobe_o.reg_select  = out_rs_q;
  assign strobe_o.data_nibble = out_nib_q;
  assign strobe_o.wait_us     = out_wait_q;
  assign strobe_o.last_strobe = out_last_q;

  // Issuing a request's final strobe returns the engine to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && cur_last) |=> state_q == clni_pkg::ST_IDLE)
    else $error("engine did not finish after last strobe");

  // The step count stays within the sequence of the running job.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == clni_pkg::ST_RUN) |->
      (job_q.is_init ? step_q <= clni_pkg::InitLast : step_q <= clni_pkg::ByteLast))
    else $error("step count out of range");

endmodule

`default_nettype wire

@@ sv/char_lcd_nibble_interface_core.sv @@
// Character LCD 4-bit bus sequencer.
// req_i takes one request per item: init sequence, command byte, data
// character or cursor move. strobe_o gives one item per enable strobe:
// RS, the four data lines, the microseconds to wait before the strobe,
// and a flag on the final strobe of each request. Bytes go out high
// nibble first. cfg_i writes the gap waited before each data character
// (reset value 50 us); it is always ready and must be written only while
// idle, which the block does not enforce. Requests pass through a
// two-entry queue to the strobe engine, so up to two requests are taken
// while a previous one still emits strobes. The first strobe of a
// request passes the queue slot, the job register and the output
// register. The engine issues one strobe per cycle while the receiver
// takes them, and passes through idle to pick up each request.
// When the receiver holds ready low, the output register keeps its item
// and the engine waits; the queue then fills and req_i.ready drops.
// Reset empties the queue, idles the engine and restores the gap value.
`default_nettype none

module char_lcd_nibble_interface_core (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  clni_req_if.sink      req_i,
  clni_cfg_if.sink      cfg_i,
  clni_strobe_if.source strobe_o
);

  logic           push;
  logic           queue_ready;
  logic           queue_valid;
  logic           pop;
  clni_pkg::job_t push_job;
  clni_pkg::job_t head_job;

  // Classification and configuration register.
  clni_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_i),
    .cfg_i         (cfg_i),
    .queue_ready_i (queue_ready),
    .push_o        (push),
    .job_o         (push_job)
  );

  // Decoupling queue between front end and strobe engine.
  clni_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .ready_o     (queue_ready),
    .pop_i       (pop),
    .valid_o     (queue_valid),
    .data_o      (head_job)
  );

  // Strobe engine with output register.
  clni_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (queue_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .strobe_o    (strobe_o)
  );

endmodule

`default_nettype wire

@@ verif/char_lcd_nibble_interface_core_test.sv @@
`timescale 1ns / 100ps

module char_lcd_nibble_interface_core_test;

  localparam int unsigned HalfPeriodNs = 4;
  localparam int unsigned TimeoutNs    = 4_000_000;
  localparam int unsigned IdlePct      = 21;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned EndCycles    = 24;
  localparam int unsigned RandomPhases = 8;
  localparam int unsigned PhaseItems   = 57;

  // Power-up sequence constants of the display controller.
  localparam logic [clni_pkg::NibW-1:0]  Half8Bit     = 4'h3;
  localparam logic [clni_pkg::NibW-1:0]  Half4Bit     = 4'h2;
  localparam logic [clni_pkg::ByteW-1:0] CmdFunc4Bit  = 8'h20;
  localparam logic [clni_pkg::ByteW-1:0] CmdClear     = 8'h01;
  localparam logic [clni_pkg::ByteW-1:0] CmdDisplayOn = 8'h0C;
  localparam logic [clni_pkg::WaitW-1:0] WaitPowerUp  = 16'd15000;
  localparam logic [clni_pkg::WaitW-1:0] WaitSecond   = 16'd5000;
  localparam logic [clni_pkg::WaitW-1:0] WaitThird    = 16'd100;
  localparam logic [clni_pkg::WaitW-1:0] WaitCommand  = 16'd50;
  localparam logic [clni_pkg::WaitW-1:0] WaitAfterClr = 16'd2050;
  localparam logic [clni_pkg::WaitW-1:0] GapMax       = 16'hFFFF;

  typedef struct packed {
    clni_pkg::op_e              op;
    logic [clni_pkg::ByteW-1:0] byte_value;
  } lcd_request_t;

  typedef struct packed {
    logic                       reg_select;
    logic [clni_pkg::NibW-1:0]  data_nibble;
    logic [clni_pkg::WaitW-1:0] wait_us;
    logic                       last_strobe;
  } lcd_strobe_t;

  logic clk;
  logic rst_n = 1'b0;

  // Testbench-owned drive registers, known from time zero.
  logic                       req_valid  = 1'b0;
  clni_pkg::op_e              req_op     = clni_pkg::OP_INIT;
  logic [clni_pkg::ByteW-1:0] req_byte   = '0;
  logic                       cfg_valid  = 1'b0;
  logic [clni_pkg::WaitW-1:0] cfg_data   = '0;
  logic                       strobe_ready = 1'b0;

  logic                       req_taken = 1'b0;
  int unsigned                idle_pct = IdlePct;
  logic                       hold_off_armed = 1'b0;
  logic                       hold_off_done = 1'b0;
  int unsigned                hold_cycles_left = 0;
  int unsigned                mismatch_count = 0;
  logic [clni_pkg::WaitW-1:0] char_gap_model = clni_pkg::GapReset;

  lcd_request_t lcd_requests[$];
  lcd_strobe_t  strobes_due[$];

  clni_req_if    req_if();
  clni_cfg_if    cfg_if();
  clni_strobe_if strobe_if();

  assign req_if.valid      = req_valid;
  assign req_if.opcode     = req_op;
  assign req_if.byte_value = req_byte;
  assign cfg_if.valid      = cfg_valid;
  assign cfg_if.data       = cfg_data;
  assign strobe_if.ready   = strobe_ready;

  char_lcd_nibble_interface_core u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .req_i   (req_if),
    .cfg_i   (cfg_if),
    .strobe_o(strobe_if)
  );

  // Free-running clock, 8 ns period.
  always begin
    clk = 1'b0;
    #HalfPeriodNs;
    clk = 1'b1;
    #HalfPeriodNs;
  end

  task automatic note_mismatch(string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Appends one enable strobe to the strobes the display should see.
  function automatic void add_strobe(logic rs, logic [clni_pkg::NibW-1:0] nib,
                                     logic [clni_pkg::WaitW-1:0] w, logic last);
    lcd_strobe_t s;
    s.reg_select  = rs;
    s.data_nibble = nib;
    s.wait_us     = w;
    s.last_strobe = last;
    strobes_due.push_back(s);
  endfunction

  // A full byte goes out as two strobes, high nibble first.
  function automatic void add_byte(logic rs, logic [clni_pkg::ByteW-1:0] b,
                                   logic [clni_pkg::WaitW-1:0] w, logic last);
    add_strobe(rs, b[7:4], w, 1'b0);
    add_strobe(rs, b[3:0], '0, last);
  endfunction

  // Works out the strobe sequence that one request produces.
  function automatic void sequence_strobes(clni_pkg::op_e op, logic [clni_pkg::ByteW-1:0] b);
    case (op)
      clni_pkg::OP_INIT: begin
        add_strobe(1'b0, Half8Bit, WaitPowerUp, 1'b0);
        add_strobe(1'b0, Half8Bit, WaitSecond, 1'b0);
        add_strobe(1'b0, Half8Bit, WaitThird, 1'b0);
        add_strobe(1'b0, Half4Bit, WaitCommand, 1'b0);
        add_byte(1'b0, CmdFunc4Bit, WaitCommand, 1'b0);
        add_byte(1'b0, CmdClear, WaitCommand, 1'b0);
        add_byte(1'b0, CmdDisplayOn, WaitAfterClr, 1'b1);
      end
      clni_pkg::OP_CMD: begin
        add_byte(1'b0, b, '0, 1'b1);
      end
      clni_pkg::OP_DATA: begin
        add_byte(1'b1, b, char_gap_model, 1'b1);
      end
      default: begin
        // A position with bit 7 set is simply absorbed by the OR.
        add_byte(1'b0, clni_pkg::CmdSetDdram | b, '0, 1'b1);
      end
    endcase
  endfunction

  // Compares one accepted strobe with the oldest one still due.
  task automatic check_strobe();
    lcd_strobe_t want;
    if (strobes_due.size() == 0) begin
      note_mismatch($sformatf("strobe with none due: rs=%0b nibble=%h wait=%0d last=%0b",
                              strobe_if.reg_select, strobe_if.data_nibble,
                              strobe_if.wait_us, strobe_if.last_strobe));
      return;
    end
    want = strobes_due.pop_front();
    if (strobe_if.reg_select !== want.reg_select)
      note_mismatch($sformatf("reg_select got %b want %b",
                              strobe_if.reg_select, want.reg_select));
    if (strobe_if.data_nibble !== want.data_nibble)
      note_mismatch($sformatf("data_nibble got %h want %h",
                              strobe_if.data_nibble, want.data_nibble));
    if (strobe_if.wait_us !== want.wait_us)
      note_mismatch($sformatf("wait_us got %0d want %0d", strobe_if.wait_us, want.wait_us));
    if (strobe_if.last_strobe !== want.last_strobe)
      note_mismatch($sformatf("last_strobe got %b want %b",
                              strobe_if.last_strobe, want.last_strobe));
  endtask

  // Monitor: tracks the gap register, predicts on each request and checks strobes.
  always @(posedge clk) begin
    req_taken <= req_valid && req_if.ready;
    if (rst_n) begin
      if (cfg_valid && cfg_if.ready) begin
        char_gap_model = cfg_data;
      end
      if (req_valid && req_if.ready) begin
        sequence_strobes(req_op, req_byte);
      end
      if (strobe_if.valid && strobe_ready) begin
        check_strobe();
      end
    end
  end

  // Request driver: offers the next queued item once the current one is taken.
  always @(negedge clk) begin
    lcd_request_t next_req;
    if (rst_n && (!req_valid || req_taken)) begin
      if (lcd_requests.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
        next_req = lcd_requests.pop_front();
        req_valid <= 1'b1;
        req_op    <= next_req.op;
        req_byte  <= next_req.byte_value;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Strobe receiver: random stalls, plus one long hold-off when armed.
  always @(negedge clk) begin
    if (hold_cycles_left != 0) begin
      hold_cycles_left <= hold_cycles_left - 1;
      strobe_ready     <= 1'b0;
    end else if (hold_off_armed && !hold_off_done) begin
      hold_cycles_left <= HoldOffCycles;
      hold_off_done    <= 1'b1;
      strobe_ready     <= 1'b0;
    end else begin
      strobe_ready <= rst_n && ($urandom_range(99, 0) >= idle_pct);
    end
  end

  function automatic void queue_request(clni_pkg::op_e op, logic [clni_pkg::ByteW-1:0] b);
    lcd_request_t r;
    r.op         = op;
    r.byte_value = b;
    lcd_requests.push_back(r);
  endfunction

  // Waits until every item is taken and every strobe due has come out.
  task automatic settle();
    @(posedge clk);
    while (lcd_requests.size() != 0 || req_valid || strobes_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Writes the character gap register; called only while the block is idle.
  task automatic write_char_gap(logic [clni_pkg::WaitW-1:0] gap);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= gap;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stimulus: directed corners first, then random phases under varied gaps.
  initial begin
    logic [clni_pkg::WaitW-1:0] gap;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset gap value; field extremes, every request kind, high cursor bit.
    queue_request(clni_pkg::OP_INIT, 8'h00);
    queue_request(clni_pkg::OP_CMD, 8'h00);
    queue_request(clni_pkg::OP_CMD, 8'hFF);
    queue_request(clni_pkg::OP_CMD, 8'hA5);
    queue_request(clni_pkg::OP_DATA, 8'h00);
    queue_request(clni_pkg::OP_DATA, 8'hFF);
    queue_request(clni_pkg::OP_DATA, 8'h5A);
    queue_request(clni_pkg::OP_CURSOR, 8'h00);
    queue_request(clni_pkg::OP_CURSOR, 8'h7F);
    queue_request(clni_pkg::OP_CURSOR, 8'h80);
    queue_request(clni_pkg::OP_CURSOR, 8'hFF);
    queue_request(clni_pkg::OP_INIT, 8'hFF);
    settle();

    // Smallest gap.
    write_char_gap('0);
    queue_request(clni_pkg::OP_DATA, 8'h3C);
    queue_request(clni_pkg::OP_DATA, 8'hC3);
    queue_request(clni_pkg::OP_CMD, 8'h01);
    settle();

    // Largest gap.
    write_char_gap(GapMax);
    queue_request(clni_pkg::OP_DATA, 8'h81);
    queue_request(clni_pkg::OP_DATA, 8'h7E);
    queue_request(clni_pkg::OP_INIT, 8'h00);
    settle();

    // Random phases, each under its own gap setting.
    for (int p = 0; p < RandomPhases; p++) begin
      case (p % 4)
        0:       gap = clni_pkg::WaitW'($urandom_range(GapMax, 0));
        1:       gap = (p < 4) ? clni_pkg::WaitW'(1) : GapMax;
        2:       gap = (p < 4) ? '0 : clni_pkg::GapReset;
        default: gap = clni_pkg::WaitW'($urandom_range(GapMax, 0));
      endcase
      write_char_gap(gap);
      // One phase runs with no idling at all; another holds the receiver off.
      idle_pct       = (p == 2) ? 0 : IdlePct;
      hold_off_armed = (p == 4);
      repeat (PhaseItems) begin
        queue_request(clni_pkg::op_e'($urandom_range(3, 0)),
                      clni_pkg::ByteW'($urandom_range(255, 0)));
      end
      settle();
    end

    repeat (EndCycles) @(posedge clk);
    if (mismatch_count == 0 && strobes_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #TimeoutNs;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
sv/clni_pkg.sv
sv/clni_if.sv
sv/clni_front.sv
sv/clni_queue.sv
sv/clni_back.sv
sv/char_lcd_nibble_interface_core.sv
verif/char_lcd_nibble_interface_core_test.sv
